/* hdl/pql_pkg.sv */
// Shared types, token kind codes, scan modes and character classes for the path query lexer.
// Depends on nothing; every other file of the block imports it.
package pql_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       text_end;
  } char_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] start_index;
    logic [31:0] end_index;
    logic [3:0]  error_mask;
    logic [3:0]  fault_count;
    logic        last;
  } token_t;

  typedef enum logic [12:0] {
    M_IDLE    = 13'b0000000000001,
    M_PUNCT   = 13'b0000000000010,
    M_INT     = 13'b0000000000100,
    M_FRAC0   = 13'b0000000001000,
    M_FRAC    = 13'b0000000010000,
    M_EXP0    = 13'b0000000100000,
    M_EXP     = 13'b0000001000000,
    M_STR     = 13'b0000010000000,
    M_ESC     = 13'b0000100000000,
    M_HEX     = 13'b0001000000000,
    M_HEXBAD  = 13'b0010000000000,
    M_KEYWORD = 13'b0100000000000,
    M_NAME    = 13'b1000000000000
  } mode_t;

  typedef struct packed {
    logic       full;
    logic       partial;
    logic [5:0] kind;
  } kw_res_t;

  localparam logic [3:0] E_PREMATURE = 4'd1;
  localparam logic [3:0] E_ESCAPE    = 4'd2;
  localparam logic [3:0] E_UNCLOSED  = 4'd4;
  localparam logic [3:0] E_CONTROL   = 4'd8;

  localparam logic [5:0] K_INTEGER  = 6'd0;
  localparam logic [5:0] K_REAL     = 6'd1;
  localparam logic [5:0] K_NULL_LIT = 6'd10;
  localparam logic [5:0] K_NAME     = 6'd16;
  localparam logic [5:0] K_END      = 6'd17;
  localparam logic [5:0] K_DOLLAR   = 6'd18;
  localparam logic [5:0] K_AT       = 6'd19;
  localparam logic [5:0] K_DOT      = 6'd20;
  localparam logic [5:0] K_EQUALS   = 6'd22;
  localparam logic [5:0] K_COLON    = 6'd23;
  localparam logic [5:0] K_COMMA    = 6'd24;
  localparam logic [5:0] K_EXCLAIM  = 6'd25;
  localparam logic [5:0] K_AMP      = 6'd27;
  localparam logic [5:0] K_STAR     = 6'd28;
  localparam logic [5:0] K_OPEN_BR  = 6'd29;
  localparam logic [5:0] K_CLOSE_BR = 6'd31;
  localparam logic [5:0] K_OPEN_BC  = 6'd32;
  localparam logic [5:0] K_CLOSE_BC = 6'd33;
  localparam logic [5:0] K_PAREN    = 6'd34;
  localparam logic [5:0] K_CLOSE_PA = 6'd35;
  localparam logic [5:0] K_LESS     = 6'd36;
  localparam logic [5:0] K_GREATER  = 6'd38;
  localparam logic [5:0] K_PLUS     = 6'd40;
  localparam logic [5:0] K_MINUS    = 6'd41;
  localparam logic [5:0] K_SLASH    = 6'd42;
  localparam logic [5:0] K_PERCENT  = 6'd43;
  localparam logic [5:0] K_STRING   = 6'd44;
  localparam logic [5:0] K_QNAME    = 6'd45;
  localparam logic [5:0] K_NONE     = 6'd0;

  localparam int KW_COUNT = 13;

  localparam logic [127:0] KW_TEXT [KW_COUNT] = '{
    "object()", "array()", "string()", "number()", "integer()", "decimal()",
    "timestamp()", "boolean()", "null()", "and", "or", "true", "false"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd8, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd11, 4'd9, 4'd6, 4'd3, 4'd2, 4'd4, 4'd5
  };
  localparam logic [5:0] KW_KIND [KW_COUNT] = '{
    6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15
  };

  // Byte j of keyword i, counted from its first character; zero past its end.
  function automatic logic [7:0] kw_char(input int i, input int j);
    logic [7:0] r;
    r = 8'd0;
    if (j < int'(KW_LEN[i])) r = KW_TEXT[i][(int'(KW_LEN[i]) - 1 - j) * 8 +: 8];
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

  function automatic logic is_cntrl(input logic [7:0] c);
    return c inside {[8'd0:8'd31], 8'd127};
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  endfunction

  function automatic logic valid_escape(input logic [7:0] c);
    return c inside {"\"", "\\", "/", " ", "_", "0", "a", "b", "e", "f", "n", "r",
                     "t", "v", "L", "N", "P"};
  endfunction

  function automatic logic is_name_end(input logic [7:0] c);
    return c inside {" ", "[", "]", ".", "=", ",", "}", "(", ")"};
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "$":     k = K_DOLLAR;
      "@":     k = K_AT;
      "=":     k = K_EQUALS;
      ":":     k = K_COLON;
      ",":     k = K_COMMA;
      "&":     k = K_AMP;
      "*":     k = K_STAR;
      "]":     k = K_CLOSE_BR;
      "{":     k = K_OPEN_BC;
      "}":     k = K_CLOSE_BC;
      "(":     k = K_PAREN;
      ")":     k = K_CLOSE_PA;
      "/":     k = K_SLASH;
      "%":     k = K_PERCENT;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] punct_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      ".":     k = K_DOT;
      "!":     k = K_EXCLAIM;
      "[":     k = K_OPEN_BR;
      "<":     k = K_LESS;
      ">":     k = K_GREATER;
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

endpackage

/* hdl/path_query_lexer.sv */
// Path query lexer: scan state, keyword lookahead and a four-entry token queue.
// Depends on pql_pkg for payload types, scan modes, token kinds and keyword tables.
// Tokens of an item are registered and visible the cycle after it is accepted, one per cycle while not stalled.
// Throughput: one character per cycle while each gives at most one token and the output
// does not stall; an item giving several tokens holds the input while the queue drains.
// Reset: synchronous; the lexer returns to idle at byte index zero with an empty queue.
module path_query_lexer
  import pql_pkg::*;
#(
  parameter int POSITION_WIDTH  = 32,
  parameter int LOOKAHEAD_DEPTH = 12
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  char_item_t char_data,
  output logic       token_valid,
  input  logic       token_stall,
  output token_t     token_data
);

  localparam int PW = POSITION_WIDTH;
  localparam int DEPTH = LOOKAHEAD_DEPTH;
  localparam int CW = $clog2(DEPTH + 1);

  typedef struct packed {
    mode_t                   mode;
    logic [PW-1:0]           ts;
    logic [DEPTH-1:0][7:0]   look;
    logic [CW-1:0]           cnt;
    logic [3:0]              hex;
    logic                    qsingle;
    logic [5:0]              pkind;
    logic [3:0]              perr;
    logic [3:0]              pcnt;
    logic                    finished;
  } st_t;

  typedef struct packed {
    st_t        s;
    logic       redo;
    logic [1:0] n;
    token_t     t0;
    token_t     t1;
  } hres_t;

  function automatic token_t mk(input logic [5:0] k, input logic [PW-1:0] s,
                                input logic [PW-1:0] e, input logic [3:0] m,
                                input logic [3:0] n);
    token_t t;
    t.token_kind  = k;
    t.start_index = 32'(s);
    t.end_index   = 32'(e);
    t.error_mask  = m;
    t.fault_count = n;
    t.last        = 1'b0;
    return t;
  endfunction

  function automatic hres_t push(input hres_t r, input token_t t);
    hres_t o;
    o = r;
    if (r.n == 2'd0) o.t0 = t;
    else o.t1 = t;
    o.n = r.n + 2'd1;
    return o;
  endfunction

  function automatic hres_t close_tok(input hres_t r, input logic [PW-1:0] e);
    hres_t o;
    o = push(r, mk(r.s.pkind, r.s.ts, e, r.s.perr, r.s.pcnt));
    o.s.mode = M_IDLE;
    o.redo = 1'b1;
    return o;
  endfunction

  function automatic st_t add_err(input st_t s, input logic [3:0] b);
    st_t o;
    o = s;
    o.perr = s.perr | b;
    if (s.pcnt != 4'd15) o.pcnt = s.pcnt + 4'd1;
    return o;
  endfunction

  function automatic kw_res_t kw_check(input logic [DEPTH-1:0][7:0] b,
                                       input logic [CW-1:0] n);
    kw_res_t r;
    logic m;
    r = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      m = (n <= CW'(KW_LEN[i]));
      for (int j = 0; j < DEPTH; j++) begin
        if (CW'(j) < n && b[j] != kw_char(i, j)) m = 1'b0;
      end
      if (m && !r.full) begin
        if (n == CW'(KW_LEN[i])) begin
          r.full = 1'b1;
          r.kind = KW_KIND[i];
        end else begin
          r.partial = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // The buffered text is no keyword: it is a null literal, a name cut at a
  // buffered parenthesis, or the start of a longer name.
  function automatic hres_t kw_fail(input hres_t r);
    hres_t o;
    logic [CW-1:0] n;
    logic [CW-1:0] p;
    logic found;
    o = r;
    n = r.s.cnt;
    o.s.cnt = '0;
    p = '0;
    found = 1'b0;
    o.redo = 1'b1;
    if (n >= CW'(4) && r.s.look[0] == "n" && r.s.look[1] == "u" &&
        r.s.look[2] == "l" && r.s.look[3] == "l") begin
      o = push(o, mk(K_NULL_LIT, r.s.ts, r.s.ts + PW'(4), 4'd0, 4'd0));
      if (n == CW'(5))
        o = push(o, mk(K_PAREN, r.s.ts + PW'(4), r.s.ts + PW'(5), 4'd0, 4'd0));
      o.s.mode = M_IDLE;
    end else begin
      for (int j = 0; j < DEPTH; j++) begin
        if (!found && CW'(j) < n && r.s.look[j] == "(") begin
          found = 1'b1;
          p = CW'(j);
        end
      end
      if (found) begin
        o = push(o, mk(K_NAME, r.s.ts, r.s.ts + PW'(p), 4'd0, 4'd0));
        o = push(o, mk(K_PAREN, r.s.ts + PW'(p), r.s.ts + PW'(p) + PW'(1), 4'd0, 4'd0));
        o.s.mode = M_IDLE;
      end else begin
        o.s.pkind = K_NAME;
        o.s.mode = M_NAME;
      end
    end
    return o;
  endfunction

  function automatic hres_t handle(input st_t si, input logic [PW-1:0] pos,
                                   input logic [7:0] c, input logic eoi);
    hres_t r;
    logic [PW-1:0] nxt;
    logic [5:0] k;
    kw_res_t kr;
    r = '0;
    r.s = si;
    nxt = pos + PW'(1);
    case (si.mode)
      M_IDLE: begin
        if (eoi) begin
          r = push(r, mk(K_END, pos, pos, 4'd0, 4'd0));
          r.s.finished = 1'b1;
        end else if (!is_space(c)) begin
          r.s.ts = pos;
          r.s.perr = 4'd0;
          r.s.pcnt = 4'd0;
          if (single_kind(c) != K_NONE) begin
            r = push(r, mk(single_kind(c), pos, nxt, 4'd0, 4'd0));
          end else if (punct_kind(c) != K_NONE) begin
            r.s.pkind = punct_kind(c);
            r.s.mode = M_PUNCT;
          end else if (c == "\"" || c == "'") begin
            r.s.qsingle = (c == "'");
            r.s.pkind = (c == "'") ? K_QNAME : K_STRING;
            r.s.mode = M_STR;
          end else if (is_digit(c)) begin
            r.s.pkind = K_INTEGER;
            r.s.mode = M_INT;
          end else begin
            r.s.pkind = K_NAME;
            r.s.look[0] = c;
            r.s.cnt = CW'(1);
            kr = kw_check(r.s.look, r.s.cnt);
            if (!kr.full && !kr.partial) begin
              r.s.cnt = '0;
              r.s.mode = M_NAME;
              r.redo = 1'b1;
            end else begin
              r.s.mode = M_KEYWORD;
            end
          end
        end
      end
      M_PUNCT: begin
        k = si.pkind;
        if (!eoi && ((k == K_DOT && c == ".") || (k == K_EXCLAIM && c == "=") ||
                     (k == K_OPEN_BR && c == "?") || (k == K_LESS && c == "=") ||
                     (k == K_GREATER && c == "="))) begin
          r = push(r, mk(k + 6'd1, si.ts, nxt, 4'd0, 4'd0));
          r.s.mode = M_IDLE;
        end else if (!eoi && k == K_DOT && is_digit(c)) begin
          r.s.pkind = K_REAL;
          r.s.mode = M_FRAC;
        end else if (!eoi && (k == K_PLUS || k == K_MINUS) && is_digit(c)) begin
          r.s.pkind = K_INTEGER;
          r.s.mode = M_INT;
        end else begin
          r = close_tok(r, pos);
        end
      end
      M_INT: begin
        if (!eoi && is_digit(c)) begin
        end else if (!eoi && c == ".") begin
          r.s.pkind = K_REAL;
          r.s.mode = M_FRAC0;
        end else if (!eoi && c == "e") begin
          r.s.mode = M_EXP0;
        end else begin
          r = close_tok(r, pos);
        end
      end
      M_FRAC0, M_FRAC: begin
        if (eoi) begin
          if (si.mode == M_FRAC0) r.s = add_err(r.s, E_PREMATURE);
          r = close_tok(r, pos);
        end else if (is_digit(c)) begin
          r.s.mode = M_FRAC;
        end else if (c == "e") begin
          r.s.mode = M_EXP0;
        end else begin
          r = close_tok(r, pos);
        end
      end
      M_EXP0, M_EXP: begin
        if (eoi) begin
          if (si.mode == M_EXP0) r.s = add_err(r.s, E_PREMATURE);
          r = close_tok(r, pos);
        end else if (is_digit(c)) begin
          r.s.mode = M_EXP;
        end else begin
          r = close_tok(r, pos);
        end
      end
      M_STR: begin
        if (eoi) begin
          r.s = add_err(add_err(r.s, E_UNCLOSED), E_PREMATURE);
          r = close_tok(r, pos);
        end else if (c == "\\") begin
          r.s.mode = M_ESC;
        end else if (is_cntrl(c)) begin
          r.s = add_err(r.s, E_CONTROL);
        end else if (c == (si.qsingle ? 8'h27 : 8'h22)) begin
          r = close_tok(r, nxt);
          r.redo = 1'b0;
        end
      end
      M_ESC: begin
        if (eoi) begin
          r.s = add_err(r.s, E_PREMATURE);
          r = close_tok(r, pos);
        end else begin
          r.s.mode = M_STR;
          if ((si.qsingle && c == "'") || valid_escape(c)) begin
          end else if (c == "x" || c == "u" || c == "U") begin
            r.s.hex = (c == "x") ? 4'd2 : (c == "u") ? 4'd4 : 4'd8;
            r.s.mode = M_HEX;
          end else begin
            r.s = add_err(r.s, E_ESCAPE);
          end
        end
      end
      M_HEX, M_HEXBAD: begin
        if (eoi) begin
          r.s = add_err(r.s, E_PREMATURE);
          r = close_tok(r, pos);
        end else begin
          // Only the first bad digit of one sequence raises an error.
          if (!is_xdigit(c) && si.mode == M_HEX) begin
            r.s = add_err(r.s, E_ESCAPE);
            r.s.mode = M_HEXBAD;
          end
          if (si.hex <= 4'd1) begin
            r.s.hex = 4'd0;
            r.s.mode = M_STR;
          end else begin
            r.s.hex = si.hex - 4'd1;
          end
        end
      end
      M_KEYWORD: begin
        if (eoi || si.cnt >= CW'(DEPTH)) begin
          r = kw_fail(r);
        end else begin
          for (int j = 0; j < DEPTH; j++) begin
            if (CW'(j) == si.cnt) r.s.look[j] = c;
          end
          r.s.cnt = si.cnt + CW'(1);
          kr = kw_check(r.s.look, r.s.cnt);
          if (!kr.full && !kr.partial) begin
            r.s.cnt = si.cnt;
            r = kw_fail(r);
          end else if (kr.full) begin
            r.s.cnt = '0;
            r = push(r, mk(kr.kind, si.ts, nxt, 4'd0, 4'd0));
            r.s.mode = M_IDLE;
          end
        end
      end
      M_NAME: begin
        if (!eoi && is_cntrl(c)) begin
          r.s = add_err(r.s, E_CONTROL);
        end else if (eoi || is_name_end(c)) begin
          r = close_tok(r, pos);
        end
      end
      default: begin
        r.s.mode = M_IDLE;
        r.redo = 1'b1;
      end
    endcase
    return r;
  endfunction

  st_t             st;
  st_t             st_next;
  logic [PW-1:0]   position;
  hres_t           h [4];
  token_t          slot [4];
  logic [2:0]      slot_n;
  token_t          q [4];
  logic [2:0]      qn;
  logic [1:0]      qh;
  logic            accept;
  logic            take;

  // An item passes through a few handling rounds at most, for example keyword,
  // idle and name; four rounds cover every case.
  always_comb begin
    h[0] = handle(st, position, char_data.char_code, char_data.text_end);
    for (int i = 1; i < 4; i++) begin
      if (h[i-1].redo) begin
        h[i] = handle(h[i-1].s, position, char_data.char_code, char_data.text_end);
      end else begin
        h[i] = '0;
        h[i].s = h[i-1].s;
      end
    end
    slot_n = 3'd0;
    for (int i = 0; i < 4; i++) slot[i] = '0;
    if (!st.finished) begin
      for (int i = 0; i < 4; i++) begin
        if (h[i].n != 2'd0 && slot_n < 3'd4) begin
          slot[slot_n[1:0]] = h[i].t0;
          slot_n = slot_n + 3'd1;
        end
        if (h[i].n == 2'd2 && slot_n < 3'd4) begin
          slot[slot_n[1:0]] = h[i].t1;
          slot_n = slot_n + 3'd1;
        end
      end
      if (slot_n != 3'd0) slot[2'(slot_n - 3'd1)].last = 1'b1;
      st_next = h[3].s;
    end else begin
      st_next = st;
    end
  end

  assign take        = token_valid && !token_stall;
  assign char_stall  = !(qn == 3'd0 || (qn == 3'd1 && take));
  assign accept      = char_valid && !char_stall;
  assign token_valid = (qn != 3'd0);
  assign token_data  = q[qh];

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode     <= M_IDLE;
      st.ts       <= '0;
      st.cnt      <= '0;
      st.hex      <= 4'd0;
      st.qsingle  <= 1'b0;
      st.pkind    <= 6'd0;
      st.perr     <= 4'd0;
      st.pcnt     <= 4'd0;
      st.finished <= 1'b0;
      position    <= '0;
      qn          <= 3'd0;
      qh          <= 2'd0;
    end else if (accept) begin
      st <= st_next;
      if (!char_data.text_end && !st.finished) position <= position + PW'(1);
      qn <= slot_n;
      qh <= 2'd0;
    end else if (take) begin
      qn <= qn - 3'd1;
      qh <= qh + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) q <= slot;
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst) qn <= 3'd4)
    else $error("token queue holds more than four entries");

  a_silent_after_end: assert property (@(posedge clk) disable iff (rst)
    (accept && st.finished) |=> (qn == 3'd0))
    else $error("token produced after the end-of-input token");

  a_position_step: assert property (@(posedge clk) disable iff (rst)
    (accept && !char_data.text_end && !st.finished) |=>
      (position == $past(position) + PW'(1)))
    else $error("byte index did not advance on a character");

  a_last_marks_tail: assert property (@(posedge clk) disable iff (rst)
    (token_valid && qn == 3'd1) |-> token_data.last)
    else $error("final queued token lacks the last flag");

endmodule
